### rtl/cartridge_bank_mapper_with_scanline_irq_defines.svh
`ifndef CARTRIDGE_BANK_MAPPER_WITH_SCANLINE_IRQ_DEFINES_SVH
`define CARTRIDGE_BANK_MAPPER_WITH_SCANLINE_IRQ_DEFINES_SVH

// same-cycle implication
`define CBM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("cbm check failed");

// next-cycle implication
`define CBM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("cbm check failed");

`endif

### rtl/cbm_pkg.sv
package cbm_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  localparam logic [2:0] KIND_PROG   = 3'd0;
  localparam logic [2:0] KIND_CHAR   = 3'd1;
  localparam logic [2:0] KIND_NAME   = 3'd2;
  localparam logic [2:0] KIND_MIRROR = 3'd3;
  localparam logic [2:0] KIND_IRQ    = 3'd4;
  localparam logic [2:0] KIND_READ   = 3'd5;

  localparam logic       CFG_ROM_COUNT = 1'b0;
  localparam logic       CFG_DIP       = 1'b1;

  localparam logic [15:0] ADDR_MASK   = 16'hF007;
  localparam logic [15:0] A_IRQ_OFF   = 16'hC002;
  localparam logic [15:0] A_IRQ_ON0   = 16'hC003;
  localparam logic [15:0] A_IRQ_ON1   = 16'hC004;
  localparam logic [15:0] A_IRQ_LOAD  = 16'hC005;
  localparam logic [15:0] A_MODE      = 16'hD000;
  localparam logic [15:0] A_MIRROR    = 16'hD001;
  localparam logic [8:0]  LAST_VISIBLE = 9'd239;
  localparam logic [8:0]  ROM_RESET    = 9'd32;
  localparam logic [7:0]  PROG_RESET   = 8'd28;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PLAN, ST_PROG, ST_CHAR, ST_NAME
  } state_e;

  typedef enum logic [2:0] {
    PH_PROG, PH_CHAR, PH_NAME, PH_READ, PH_IRQ
  } phase_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  data;
    logic [8:0]  scanline;
    logic        rendering_on;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  result_kind;
    logic [2:0]  slot;
    logic [18:0] bank_number;
    logic [1:0]  mirroring;
    logic [7:0]  read_data;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic       accept;
    logic       plan;
    logic       emit;
    phase_e     phase;
    logic [2:0] idx;
    logic       last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_read;
    logic is_tick;
    logic need_prog;
    logic need_char;
    logic need_name;
    logic prog_five;
    logic name_skip;
    logic name_ext;
    logic irq_hit;
  } dp_status_t;

endpackage

### rtl/cbm_ctrl.sv
module cbm_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  cbm_pkg::dp_status_t status_i,
  output cbm_pkg::ctrl_cmd_t  cmd_o,
  output logic                busy_o
);
  import cbm_pkg::*;

  state_e     state_q, state_d;
  logic [2:0] idx_q, idx_d;
  logic       char_go_q, char_go_d;
  logic       name_go_q, name_go_d;
  logic       prog_end;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= 3'd0;
      char_go_q <= 1'b0;
      name_go_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      char_go_q <= char_go_d;
      name_go_q <= name_go_d;
    end
  end

  assign busy_o   = (state_q != ST_IDLE);
  assign prog_end = (idx_q == (status_i.prog_five ? 3'd4 : 3'd3));

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q + 3'd1;
    char_go_d = char_go_q;
    name_go_d = name_go_q;
    cmd_o     = '{accept: 1'b0, plan: 1'b0, emit: 1'b0, phase: PH_PROG,
                  idx: idx_q, last: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        idx_d = 3'd0;
        if (start_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_PLAN;
        end
      end
      ST_PLAN: begin
        cmd_o.plan = 1'b1;
        cmd_o.last = 1'b1;
        idx_d      = 3'd0;
        char_go_d  = status_i.need_char;
        name_go_d  = status_i.need_name & ~status_i.name_skip;
        state_d    = ST_IDLE;
        if (status_i.is_read) begin
          cmd_o.emit  = 1'b1;
          cmd_o.phase = PH_READ;
        end else if (status_i.is_tick) begin
          cmd_o.emit  = status_i.irq_hit;
          cmd_o.phase = PH_IRQ;
        end else if (status_i.need_prog) begin
          state_d = ST_PROG;
        end else if (char_go_d) begin
          state_d = ST_CHAR;
        end else if (name_go_d) begin
          state_d = ST_NAME;
        end
      end
      ST_PROG: begin
        cmd_o.emit  = 1'b1;
        cmd_o.phase = PH_PROG;
        cmd_o.last  = prog_end & ~char_go_q & ~name_go_q;
        if (prog_end) begin
          idx_d = 3'd0;
          priority if (char_go_q) state_d = ST_CHAR;
          else if (name_go_q)     state_d = ST_NAME;
          else                    state_d = ST_IDLE;
        end
      end
      ST_CHAR: begin
        cmd_o.emit  = 1'b1;
        cmd_o.phase = PH_CHAR;
        cmd_o.last  = (idx_q == 3'd7) & ~name_go_q;
        if (idx_q == 3'd7) begin
          idx_d   = 3'd0;
          state_d = name_go_q ? ST_NAME : ST_IDLE;
        end
      end
      ST_NAME: begin
        cmd_o.emit  = 1'b1;
        cmd_o.phase = PH_NAME;
        cmd_o.last  = ~status_i.name_ext | (idx_q == 3'd3);
        if (cmd_o.last) begin
          idx_d   = 3'd0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

### rtl/cbm_dp.sv
module cbm_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [8:0]          cfg_data_i,
  input  cbm_pkg::in_item_t   item_i,
  input  cbm_pkg::ctrl_cmd_t  cmd_i,
  output cbm_pkg::dp_status_t status_o,
  output logic                result_valid_o,
  output cbm_pkg::out_item_t  result_o
);
  import cbm_pkg::*;

  logic [8:0] rom_q;
  logic       dip_q;
  logic [7:0] prg_q [4];
  logic [7:0] chl_q [8];
  logic [7:0] chh_q [8];
  logic [7:0] nml_q [4];
  logic [7:0] nmh_q [4];
  logic [1:0] prg_mode_q, chr_mode_q, mirror_q;
  logic       top_q, low_win_q, ext_q;
  logic [7:0] irq_count_q, irq_reload_q;
  logic       armed_q;
  logic       is_read_q, is_tick_q, need_prog_q, need_char_q, need_name_q;
  logic       strobe_q;
  out_item_t  res_q, res_d;

  logic [15:0] a;
  logic        is_write;
  logic        w_prog, w_chl, w_chh, w_nml, w_nmh, w_mode, w_mir;
  logic        tick_ok;
  logic [3:0]  name_hit;

  assign a        = item_i.address & ADDR_MASK;
  assign is_write = (item_i.operation == OP_WRITE);
  assign w_prog   = (a[15:12] == 4'h8) && (a[2] == 1'b0);
  assign w_chl    = (a[15:12] == 4'h9);
  assign w_chh    = (a[15:12] == 4'hA);
  assign w_nml    = (a[15:12] == 4'hB) && (a[2] == 1'b0);
  assign w_nmh    = (a[15:12] == 4'hB) && (a[2] == 1'b1);
  assign w_mode   = (a == A_MODE);
  assign w_mir    = (a == A_MIRROR);
  assign tick_ok  = (item_i.scanline <= LAST_VISIBLE) && item_i.rendering_on;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      name_hit[i] = (nmh_q[i] == 8'd0) && (nml_q[i] == 8'(i));
    end
  end

  assign status_o = '{is_read: is_read_q, is_tick: is_tick_q,
                      need_prog: need_prog_q, need_char: need_char_q,
                      need_name: need_name_q,
                      prog_five: (prg_mode_q == 2'd2) && !top_q && low_win_q,
                      name_skip: ext_q && (name_hit != 4'd0),
                      name_ext: ext_q,
                      irq_hit: (irq_count_q == 8'd0) && armed_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rom_q <= ROM_RESET;
      dip_q <= 1'b1;
      for (int i = 0; i < 4; i++) begin
        prg_q[i] <= PROG_RESET + 8'(i);
        nml_q[i] <= 8'd0;
        nmh_q[i] <= 8'd0;
      end
      for (int i = 0; i < 8; i++) begin
        chl_q[i] <= 8'(i);
        chh_q[i] <= 8'd0;
      end
      prg_mode_q   <= 2'd0;
      chr_mode_q   <= 2'd0;
      mirror_q     <= 2'd0;
      top_q        <= 1'b0;
      low_win_q    <= 1'b0;
      ext_q        <= 1'b0;
      irq_count_q  <= 8'd0;
      irq_reload_q <= 8'd0;
      armed_q      <= 1'b0;
      is_read_q    <= 1'b0;
      is_tick_q    <= 1'b0;
      need_prog_q  <= 1'b0;
      need_char_q  <= 1'b0;
      need_name_q  <= 1'b0;
      strobe_q     <= 1'b0;
    end else begin
      strobe_q <= cmd_i.emit;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_ROM_COUNT: rom_q <= cfg_data_i;
          CFG_DIP:       dip_q <= cfg_data_i[0];
          default:       ;
        endcase
      end
      if (cmd_i.plan && need_name_q && status_o.name_skip) begin
        ext_q <= 1'b0;
      end
      if (cmd_i.accept) begin
        is_read_q   <= (item_i.operation == OP_READ);
        is_tick_q   <= (item_i.operation == OP_TICK) && tick_ok;
        need_prog_q <= is_write && (w_prog || w_mode);
        need_char_q <= is_write && (w_chl || w_chh || w_mode);
        need_name_q <= is_write && (w_nml || w_nmh || w_mode || w_mir);
        if (item_i.operation == OP_TICK && tick_ok) begin
          irq_count_q <= irq_count_q - 8'd1;
        end
        if (is_write) begin
          if (w_prog) prg_q[a[1:0]] <= item_i.data;
          if (w_chl)  chl_q[a[2:0]] <= item_i.data;
          if (w_chh)  chh_q[a[2:0]] <= item_i.data;
          if (w_nml)  nml_q[a[1:0]] <= item_i.data;
          if (w_nmh)  nmh_q[a[1:0]] <= item_i.data;
          if (a == A_IRQ_OFF) armed_q <= 1'b0;
          if ((a == A_IRQ_ON0 || a == A_IRQ_ON1) && !armed_q) begin
            armed_q     <= 1'b1;
            irq_count_q <= irq_reload_q;
          end
          if (a == A_IRQ_LOAD) begin
            irq_count_q  <= item_i.data;
            irq_reload_q <= item_i.data;
          end
          if (w_mode) begin
            low_win_q  <= item_i.data[7];
            top_q      <= item_i.data[2];
            prg_mode_q <= item_i.data[1:0];
            chr_mode_q <= item_i.data[4:3];
            ext_q      <= item_i.data[5];
          end
          if (w_mir) mirror_q <= item_i.data[1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) res_q <= res_d;
  end

  logic [2:0]  p_slot;
  logic [1:0]  p_j;
  logic [18:0] rom_w;
  logic [15:0] cb [8];
  logic [2:0]  ci;
  logic [1:0]  ni;

  assign rom_w  = {10'd0, rom_q};
  assign p_slot = status_o.prog_five ? cmd_i.idx + 3'd3 : cmd_i.idx + 3'd4;
  assign p_j    = p_slot[1:0];
  assign ci     = cmd_i.idx;
  assign ni     = cmd_i.idx[1:0];

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      cb[i] = {chh_q[i], chl_q[i]};
    end
  end

  always_comb begin
    res_d      = '0;
    res_d.last = cmd_i.last;
    unique case (cmd_i.phase)
      PH_PROG: begin
        res_d.result_kind = KIND_PROG;
        res_d.slot        = p_slot;
        unique case (prg_mode_q)
          2'd0: res_d.bank_number = rom_w - 19'(3'd4 - {1'b0, p_j});
          2'd1: begin
            unique case (p_j)
              2'd0: res_d.bank_number = {10'd0, prg_q[1], 1'b0};
              2'd1: res_d.bank_number = {10'd0, prg_q[1], 1'b1};
              2'd2: res_d.bank_number = rom_w - 19'd2;
              default: res_d.bank_number = rom_w - 19'd1;
            endcase
          end
          2'd2: begin
            priority if (top_q)         res_d.bank_number = {11'd0, prg_q[p_j]};
            else if (p_slot == 3'd3)    res_d.bank_number = {11'd0, prg_q[3]};
            else if (p_j == 2'd3)       res_d.bank_number = rom_w - 19'd1;
            else                        res_d.bank_number = {11'd0, prg_q[p_j]};
          end
          default: res_d.bank_number = {11'd0, prg_q[2'd3 - p_j]};
        endcase
      end
      PH_CHAR: begin
        res_d.result_kind = KIND_CHAR;
        res_d.slot        = ci;
        unique case (chr_mode_q)
          2'd0: res_d.bank_number = {cb[0], ci};
          2'd1: res_d.bank_number = {1'b0, cb[{ci[2], 2'b00}], ci[1:0]};
          2'd2: res_d.bank_number = {2'b00, cb[{ci[2:1], 1'b0}], ci[0]};
          default: res_d.bank_number = {3'd0, cb[ci]};
        endcase
      end
      PH_NAME: begin
        if (ext_q) begin
          res_d.result_kind = KIND_NAME;
          res_d.slot        = {1'b0, ni};
          res_d.bank_number = {3'd0, nmh_q[ni], nml_q[ni]};
        end else begin
          res_d.result_kind = KIND_MIRROR;
          res_d.mirroring   = mirror_q[1] ? 2'd2 : mirror_q;
        end
      end
      PH_READ: begin
        res_d.result_kind = KIND_READ;
        res_d.read_data   = dip_q ? 8'hFF : 8'h00;
      end
      PH_IRQ:  res_d.result_kind = KIND_IRQ;
      default: res_d = '0;
    endcase
  end

  assign result_valid_o = strobe_q;
  assign result_o       = res_q;

endmodule

### rtl/cartridge_bank_mapper_with_scanline_irq.sv
// channel    | handshake                | payload
// item in    | start_i high, busy_o low | item_i
// result out | result_valid_o, 1 cycle  | result_o
// config     | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// An item is accepted in ST_IDLE and planned in ST_PLAN; for a write the slot
// sequencer then issues one result per cycle, up to 17 for a mode write.
// Each result shows in the cycle after it is issued; busy_o is low again in the
// cycle that shows the last one. Reset is asynchronous and returns all mapping
// registers to their reset values.
// The receiver cannot stall; results are never held.
module cartridge_bank_mapper_with_scanline_irq (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  cbm_pkg::in_item_t  item_i,
  output logic               result_valid_o,
  output cbm_pkg::out_item_t result_o,
  input  logic               cfg_we_i,
  input  logic               cfg_index_i,
  input  logic [8:0]         cfg_data_i
);
  import cbm_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  cbm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o)
  );

  cbm_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .item_i         (item_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

### rtl/cbm_checker.sv
`include "cartridge_bank_mapper_with_scanline_irq_defines.svh"

module cbm_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               result_valid_o,
  input cbm_pkg::out_item_t result_o
);
  import cbm_pkg::*;

  `CBM_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)
  `CBM_ASSERT_NEXT(a_accept_quiet, start_i && !busy_o, !result_valid_o)
  `CBM_ASSERT_NEXT(a_run_unbroken, result_valid_o && !result_o.last, result_valid_o)
  `CBM_ASSERT_NOW(a_read_single, result_valid_o && result_o.result_kind == KIND_READ, result_o.last)

endmodule

bind cartridge_bank_mapper_with_scanline_irq cbm_checker u_cbm_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
